### hw/rtl/smle_pkg.sv
// shared constants, types and coefficient tables for the stellar lifetime evaluator
`default_nettype none
package smle_pkg;

    localparam int MASS_FRAC_BITS_DEF = 12;
    localparam int OUT_FRAC_BITS_DEF  = 24;
    localparam int MASS_W  = 24;
    localparam int RATIO_W = 16;
    localparam int OUT_W   = 40;
    localparam int LFRAC   = 24;
    localparam int NORM    = 30;
    localparam int NBANDS  = 5;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NEG  = 2'd1,
        ST_ZERO = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    typedef struct packed {
        logic               neg;
        logic               zero;
        logic               hi;
        logic [RATIO_W-1:0] ratio;
    } t_side;

    // slopes in Q.16, intercepts as beta*log2(10) in Q.24
    localparam logic signed [18:0] ALPHA_Q16 [NBANDS] = '{
        -19'sd42893, -19'sd242483, -19'sd164495, -19'sd116654, -19'sd56361
    };
    localparam logic signed [31:0] BETA_Q24 [NBANDS] = '{
        32'sd55732705, 32'sd75239152, 32'sd42914183, 32'sd9474560, -32'sd52388743
    };
    localparam logic signed [18:0] HI_SLOPE_Q16 = -19'sd121242;
    localparam logic signed [31:0] HI_COEF_Q24  = 32'sd4412985;

    typedef logic [LFRAC:0][NORM:0] t_roots;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        logic [63:0] vv;
        res = '0;
        bt  = 64'd1 << 62;
        vv  = v;
        for (int i = 0; i < 32; i++) begin
            if (vv >= res + bt) begin
                vv  = vv - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.30, by k successive truncating square roots of 2
    function automatic t_roots calc_roots();
        t_roots      tab;
        logic [63:0] r;
        tab = '0;
        r   = 64'd2 << NORM;
        for (int k = 1; k <= LFRAC; k++) begin
            r = isqrt64(r << NORM);
            tab[k] = r[NORM:0];
        end
        return tab;
    endfunction

    localparam t_roots EXP_ROOTS = calc_roots();

endpackage
`default_nettype wire

### hw/rtl/smle_log2.sv
// front end: special cases, band select and pipelined log2 by repeated squaring
`default_nettype none
module smle_log2 #(
    parameter int MASS_FRAC_BITS = smle_pkg::MASS_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic [smle_pkg::MASS_W-1:0]         i_star_mass,
    input  wire logic [smle_pkg::RATIO_W-1:0]        i_post_ms_ratio,
    output logic                                     o_valid,
    output logic signed [31:0]                       o_lg,
    output logic signed [18:0]                       o_alpha,
    output logic signed [31:0]                       o_beta,
    output smle_pkg::t_side                          o_side
);
    localparam int NST  = smle_pkg::LFRAC;
    localparam int XW   = smle_pkg::NORM + 1;
    localparam logic [27:0] T_B0 = 28'(13) << MASS_FRAC_BITS;
    localparam logic [27:0] T_B1 = 28'(3) << MASS_FRAC_BITS;
    localparam logic [27:0] T_B2 = 28'(7) << MASS_FRAC_BITS;
    localparam logic [27:0] T_B3 = 28'(15) << MASS_FRAC_BITS;
    localparam logic [27:0] T_HI = 28'(60) << MASS_FRAC_BITS;

    logic [4:0]         p;
    logic [27:0]        m_ext;
    logic [27:0]        m10;
    logic [XW-1:0]      n_x0;
    logic signed [7:0]  n_lgi0;
    logic signed [18:0] n_alpha0;
    logic signed [31:0] n_beta0;
    smle_pkg::t_side    n_side0;

    logic [NST:0]       r_v;
    logic [XW-1:0]      r_x     [NST+1];
    logic [NST-1:0]     r_fr    [NST+1];
    logic signed [7:0]  r_lgi   [NST+1];
    logic signed [18:0] r_alpha [NST+1];
    logic signed [31:0] r_beta  [NST+1];
    smle_pkg::t_side    r_side  [NST+1];

    logic [61:0]        sq  [NST+1];
    logic [XW-1:0]      n_x [NST+1];
    logic [NST-1:0]     n_fr[NST+1];

    always_comb begin
        p = '0;
        for (int i = 0; i < smle_pkg::MASS_W - 1; i++) begin
            if (i_star_mass[i]) p = 5'(i);
        end
        m_ext  = 28'(i_star_mass);
        m10    = m_ext * 28'd10;
        n_x0   = XW'(i_star_mass) << (5'd30 - p);
        n_lgi0 = 8'(p) - 8'(MASS_FRAC_BITS);
        n_side0.neg   = i_star_mass[smle_pkg::MASS_W-1];
        n_side0.zero  = (i_star_mass == '0);
        n_side0.hi    = (m_ext > T_HI);
        n_side0.ratio = i_post_ms_ratio;
        // a mass on a band edge belongs to the lower band
        if (m_ext > T_HI) begin
            n_alpha0 = smle_pkg::HI_SLOPE_Q16;
            n_beta0  = smle_pkg::HI_COEF_Q24;
        end else if (m10 <= T_B0) begin
            n_alpha0 = smle_pkg::ALPHA_Q16[0];
            n_beta0  = smle_pkg::BETA_Q24[0];
        end else if (m_ext <= T_B1) begin
            n_alpha0 = smle_pkg::ALPHA_Q16[1];
            n_beta0  = smle_pkg::BETA_Q24[1];
        end else if (m_ext <= T_B2) begin
            n_alpha0 = smle_pkg::ALPHA_Q16[2];
            n_beta0  = smle_pkg::BETA_Q24[2];
        end else if (m_ext <= T_B3) begin
            n_alpha0 = smle_pkg::ALPHA_Q16[3];
            n_beta0  = smle_pkg::BETA_Q24[3];
        end else begin
            n_alpha0 = smle_pkg::ALPHA_Q16[4];
            n_beta0  = smle_pkg::BETA_Q24[4];
        end
    end

    // one squaring per stage, one fraction bit out of each
    always_comb begin
        sq[0]   = '0;
        n_x[0]  = '0;
        n_fr[0] = '0;
        for (int g = 1; g <= NST; g++) begin
            sq[g] = 62'(r_x[g-1]) * 62'(r_x[g-1]);
            if (sq[g][61]) begin
                n_x[g] = sq[g][61:31];
            end else begin
                n_x[g] = sq[g][60:30];
            end
            n_fr[g] = {r_fr[g-1][NST-2:0], sq[g][61]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v        <= {r_v[NST-1:0], i_valid};
            r_x[0]     <= n_x0;
            r_fr[0]    <= '0;
            r_lgi[0]   <= n_lgi0;
            r_alpha[0] <= n_alpha0;
            r_beta[0]  <= n_beta0;
            r_side[0]  <= n_side0;
            for (int g = 1; g <= NST; g++) begin
                r_x[g]     <= n_x[g];
                r_fr[g]    <= n_fr[g];
                r_lgi[g]   <= r_lgi[g-1];
                r_alpha[g] <= r_alpha[g-1];
                r_beta[g]  <= r_beta[g-1];
                r_side[g]  <= r_side[g-1];
            end
        end
    end

    assign o_valid = r_v[NST];
    assign o_lg    = $signed({r_lgi[NST], r_fr[NST]});
    assign o_alpha = r_alpha[NST];
    assign o_beta  = r_beta[NST];
    assign o_side  = r_side[NST];

endmodule
`default_nettype wire

### hw/rtl/smle_exp2.sv
// exponent forming and pipelined exp2 by products of square roots of two
`default_nettype none
module smle_exp2 (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic signed [31:0]   i_lg,
    input  wire logic signed [18:0]   i_alpha,
    input  wire logic signed [31:0]   i_beta,
    input  wire smle_pkg::t_side      i_side,
    output logic                      o_valid,
    output logic [smle_pkg::NORM:0]   o_acc,
    output logic signed [15:0]        o_n,
    output smle_pkg::t_side           o_side
);
    localparam int NST = smle_pkg::LFRAC;
    localparam int AW  = smle_pkg::NORM + 1;

    logic               r_va;
    logic signed [50:0] r_prod;
    logic signed [31:0] r_beta_a;
    smle_pkg::t_side    r_side_a;

    logic signed [39:0] e;

    logic [NST:0]       r_v;
    logic [AW-1:0]      r_acc [NST+1];
    logic [NST-1:0]     r_f   [NST+1];
    logic signed [15:0] r_n   [NST+1];
    smle_pkg::t_side    r_side[NST+1];

    logic [61:0]        pr    [NST+1];
    logic [AW-1:0]      n_acc [NST+1];

    // floor of the slope product, then the intercept
    assign e = 40'(r_prod >>> 16) + 40'(r_beta_a);

    always_comb begin
        pr[0]    = '0;
        n_acc[0] = '0;
        for (int k = 1; k <= NST; k++) begin
            pr[k] = 62'(r_acc[k-1]) * 62'(smle_pkg::EXP_ROOTS[k]);
            if (r_f[k-1][NST-k]) begin
                n_acc[k] = pr[k][60:30];
            end else begin
                n_acc[k] = r_acc[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_v  <= '0;
        end else if (i_en) begin
            r_va      <= i_valid;
            r_prod    <= i_alpha * i_lg;
            r_beta_a  <= i_beta;
            r_side_a  <= i_side;
            r_v       <= {r_v[NST-1:0], r_va};
            r_acc[0]  <= AW'(1) << smle_pkg::NORM;
            r_f[0]    <= e[NST-1:0];
            r_n[0]    <= e[39:24];
            r_side[0] <= r_side_a;
            for (int k = 1; k <= NST; k++) begin
                r_acc[k]  <= n_acc[k];
                r_f[k]    <= r_f[k-1];
                r_n[k]    <= r_n[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[NST];
    assign o_acc   = r_acc[NST];
    assign o_n     = r_n[NST];
    assign o_side  = r_side[NST];

endmodule
`default_nettype wire

### hw/rtl/smle_post.sv
// output scaling, high-mass offset, ratio scale, saturation and result register
`default_nettype none
module smle_post #(
    parameter int OUT_FRAC_BITS = smle_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [smle_pkg::NORM:0]       i_acc,
    input  wire logic signed [15:0]            i_n,
    input  wire smle_pkg::t_side               i_side,
    output logic                               o_valid,
    output logic [smle_pkg::OUT_W-1:0]         o_lifetime_gyr,
    output logic [1:0]                         o_status
);
    localparam int OW = smle_pkg::OUT_W;
    localparam logic [63:0] C003 = ((64'd3 << OUT_FRAC_BITS) + 64'd500) / 64'd1000;

    logic signed [17:0] s;
    logic [17:0]        ns;
    logic [OW-1:0]      n_t1;
    logic               n_sat1;
    logic [OW:0]        t2;
    logic [44:0]        scaled;
    logic               sat4;

    logic               r_v1, r_v2, r_v3, r_vout;
    logic [OW-1:0]      r_t1, r_t2;
    logic               r_sat1, r_sat2, r_sat3;
    smle_pkg::t_side    r_side1, r_side2, r_side3;
    logic [56:0]        r_prod3;
    logic [OW-1:0]      r_life;
    logic [1:0]         r_stat;

    always_comb begin
        s      = 18'(i_n) + 18'(OUT_FRAC_BITS) - 18'(smle_pkg::NORM);
        ns     = -s;
        n_sat1 = 1'b0;
        if (!s[17]) begin
            if (s > 18'sd9) begin
                n_sat1 = 1'b1;
                n_t1   = smle_pkg::OUT_MAX;
            end else begin
                n_t1 = OW'(i_acc) << s[3:0];
            end
        end else if (ns >= 18'd31) begin
            n_t1 = '0;
        end else begin
            n_t1 = OW'(i_acc) >> ns[4:0];
        end
    end

    assign t2     = (OW+1)'(r_t1) + (r_side1.hi ? (OW+1)'(C003) : '0);
    assign scaled = r_prod3[56:12];
    assign sat4   = r_sat3 || (scaled > 45'(smle_pkg::OUT_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vout <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_t1    <= n_t1;
            r_sat1  <= n_sat1;
            r_side1 <= i_side;

            r_v2    <= r_v1;
            r_t2    <= t2[OW-1:0];
            r_sat2  <= r_sat1 || t2[OW];
            r_side2 <= r_side1;

            r_v3    <= r_v2;
            r_prod3 <= 57'(r_t2) * 57'(17'd4096 + 17'(r_side2.ratio));
            r_sat3  <= r_sat2;
            r_side3 <= r_side2;

            r_vout  <= r_v3;
            if (r_side3.neg) begin
                r_life <= '0;
                r_stat <= smle_pkg::ST_NEG;
            end else if (r_side3.zero) begin
                r_life <= smle_pkg::OUT_MAX;
                r_stat <= smle_pkg::ST_ZERO;
            end else if (sat4) begin
                r_life <= smle_pkg::OUT_MAX;
                r_stat <= smle_pkg::ST_SAT;
            end else begin
                r_life <= scaled[OW-1:0];
                r_stat <= smle_pkg::ST_OK;
            end
        end
    end

    assign o_valid        = r_vout;
    assign o_lifetime_gyr = r_life;
    assign o_status       = r_stat;

endmodule
`default_nettype wire

### hw/rtl/stellar_mass_lifetime_eval_unit.sv
// top level of the stellar mass to lifetime evaluator
//
// input channel: i_valid, o_stall, i_star_mass (signed Q11.12 by default),
// i_post_ms_ratio (unsigned Q4.12). a transfer happens when i_valid is high
// and o_stall low. output channel: o_valid, i_stall, o_lifetime_gyr
// (unsigned, OUT_FRAC_BITS fraction bits) and o_status.
// every input gives exactly one result, in order.
// the pipeline has 25 stages of log2 squaring, 26 of exponent forming
// and exp2 products, 4 of scaling and output. throughput is one item per
// cycle while no result waits with i_stall high, set by one multiplier per
// stage in each of the squaring and exp2 chains.
// the whole pipeline advances together; while a result waits with i_stall
// high every stage holds and o_stall is raised, so nothing is lost or
// repeated. reset clears all valid bits; no result is pending afterwards.
// negative mass gives 0 with status 1, zero mass all ones with status 2,
// any overflow all ones with status 3.
`default_nettype none
module stellar_mass_lifetime_eval_unit #(
    parameter int MASS_FRAC_BITS = smle_pkg::MASS_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS  = smle_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [smle_pkg::MASS_W-1:0]   i_star_mass,
    input  wire logic [smle_pkg::RATIO_W-1:0]  i_post_ms_ratio,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [smle_pkg::OUT_W-1:0]         o_lifetime_gyr,
    output logic [1:0]                         o_status
);
    logic               en;
    logic               lg_valid;
    logic signed [31:0] lg;
    logic signed [18:0] lg_alpha;
    logic signed [31:0] lg_beta;
    smle_pkg::t_side    lg_side;
    logic               ex_valid;
    logic [smle_pkg::NORM:0] ex_acc;
    logic signed [15:0] ex_n;
    smle_pkg::t_side    ex_side;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    smle_log2 #(.MASS_FRAC_BITS(MASS_FRAC_BITS)) u_log2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_star_mass(i_star_mass), .i_post_ms_ratio(i_post_ms_ratio),
        .o_valid(lg_valid), .o_lg(lg), .o_alpha(lg_alpha), .o_beta(lg_beta),
        .o_side(lg_side)
    );

    smle_exp2 u_exp2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(lg_valid),
        .i_lg(lg), .i_alpha(lg_alpha), .i_beta(lg_beta), .i_side(lg_side),
        .o_valid(ex_valid), .o_acc(ex_acc), .o_n(ex_n), .o_side(ex_side)
    );

    smle_post #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_post (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(ex_valid),
        .i_acc(ex_acc), .i_n(ex_n), .i_side(ex_side),
        .o_valid(o_valid), .o_lifetime_gyr(o_lifetime_gyr), .o_status(o_status)
    );

endmodule
`default_nettype wire

### hw/rtl/smle_checker.sv
// port-level checks for the stellar lifetime evaluator, bound to the top level
`default_nettype none
module smle_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic [smle_pkg::MASS_W-1:0]   i_star_mass,
    input wire logic [smle_pkg::RATIO_W-1:0]  i_post_ms_ratio,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [smle_pkg::OUT_W-1:0]    o_lifetime_gyr,
    input wire logic [1:0]                    o_status
);
    // input held back only while a result is stuck at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked output");

    a_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == smle_pkg::ST_NEG) |-> (o_lifetime_gyr == '0))
        else $error("negative mass result not zero");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == smle_pkg::ST_ZERO || o_status == smle_pkg::ST_SAT))
        |-> (o_lifetime_gyr == smle_pkg::OUT_MAX))
        else $error("infinite or saturated result not all ones");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_lifetime_gyr) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind stellar_mass_lifetime_eval_unit smle_checker u_smle_checker (.*);
`default_nettype wire
